// ----- rtl/stcq_pkg.sv -----
`timescale 1ns / 1ps

package stcq_pkg;

  localparam int unsigned DUE_W   = 32;
  localparam int unsigned CODE_W  = 8;
  localparam int unsigned PORT_PW = 32;

  typedef enum logic [1:0] {
    FN_ADD    = 2'd0,
    FN_REMOVE = 2'd1,
    FN_POLL   = 2'd2
  } func_t;

  typedef enum logic [1:0] {
    ST_DONE     = 2'd0,
    ST_FULL     = 2'd1,
    ST_BAD_SLOT = 2'd2,
    ST_NONE_DUE = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    OP_HOLD   = 2'd0,
    OP_INSERT = 2'd1,
    OP_DELETE = 2'd2
  } cell_op_t;

  // broadcast to every cell of the chain
  typedef struct packed {
    cell_op_t            op;
    logic [DUE_W-1:0]    due;
    logic [CODE_W-1:0]   cmd;
    logic [CODE_W-1:0]   sub;
  } cell_ctrl_t;

endpackage

// ----- rtl/stcq_cell.sv -----
`timescale 1ns / 1ps

module stcq_cell #(
  parameter int unsigned PAYLOAD_BITS = 32
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  stcq_pkg::cell_ctrl_t            ctrl,
  input  logic [PAYLOAD_BITS-1:0]         new_data,
  input  logic                            del_sel,
  input  logic                            left_cond,
  input  logic [stcq_pkg::DUE_W-1:0]      left_due,
  input  logic [stcq_pkg::CODE_W-1:0]     left_cmd,
  input  logic [stcq_pkg::CODE_W-1:0]     left_sub,
  input  logic [PAYLOAD_BITS-1:0]         left_data,
  input  logic                            left_valid,
  input  logic [stcq_pkg::DUE_W-1:0]      right_due,
  input  logic [stcq_pkg::CODE_W-1:0]     right_cmd,
  input  logic [stcq_pkg::CODE_W-1:0]     right_sub,
  input  logic [PAYLOAD_BITS-1:0]         right_data,
  input  logic                            right_valid,
  output logic                            cond,
  output logic [stcq_pkg::DUE_W-1:0]      due,
  output logic [stcq_pkg::CODE_W-1:0]     cmd,
  output logic [stcq_pkg::CODE_W-1:0]     sub,
  output logic [PAYLOAD_BITS-1:0]         data,
  output logic                            valid
);

  logic [stcq_pkg::DUE_W-1:0]  due_r,  due_nxt;
  logic [stcq_pkg::CODE_W-1:0] cmd_r,  cmd_nxt;
  logic [stcq_pkg::CODE_W-1:0] sub_r,  sub_nxt;
  logic [PAYLOAD_BITS-1:0]     data_r, data_nxt;
  logic                        valid_r, valid_nxt;

  // true where the new entry belongs at or before this cell
  assign cond = !valid_r || (due_r > ctrl.due);

  always_comb begin
    due_nxt   = due_r;
    cmd_nxt   = cmd_r;
    sub_nxt   = sub_r;
    data_nxt  = data_r;
    valid_nxt = valid_r;
    unique case (ctrl.op)
      stcq_pkg::OP_INSERT: begin
        if (cond && left_cond) begin
          due_nxt   = left_due;
          cmd_nxt   = left_cmd;
          sub_nxt   = left_sub;
          data_nxt  = left_data;
          valid_nxt = left_valid;
        end else if (cond) begin
          due_nxt   = ctrl.due;
          cmd_nxt   = ctrl.cmd;
          sub_nxt   = ctrl.sub;
          data_nxt  = new_data;
          valid_nxt = 1'b1;
        end
      end
      stcq_pkg::OP_DELETE: begin
        if (del_sel) begin
          due_nxt   = right_due;
          cmd_nxt   = right_cmd;
          sub_nxt   = right_sub;
          data_nxt  = right_data;
          valid_nxt = right_valid;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    due_r  <= due_nxt;
    cmd_r  <= cmd_nxt;
    sub_r  <= sub_nxt;
    data_r <= data_nxt;
  end

  assign due   = due_r;
  assign cmd   = cmd_r;
  assign sub   = sub_r;
  assign data  = data_r;
  assign valid = valid_r;

endmodule

// ----- rtl/sorted_timed_command_queue_unit.sv -----
`timescale 1ns / 1ps

// Sorted timed command queue: up to QUEUE_DEPTH commands held in a row of cells,
// ordered by due time (now + delay, saturating), active entries packed from
// cell 0. Each transfer on the input (tuser = add, remove by slot or poll) gives
// exactly one result in the output register on the following clock, and a new item is
// taken every cycle while the result register is free or being drained, so the
// rate is one item per clock. That figure comes from every cell comparing the new
// due time against its own and shifting left or right in the same cycle; the
// critical path is the 33-bit add, one 32-bit compare per cell and the one-hot
// selection of the insert slot. Cells come up empty straight after reset, with
// no clearing pass. A poll pops the head only when its due time is strictly
// before now; status 3 answers an empty or not-yet-due head and the unused code.
module sorted_timed_command_queue_unit #(
  parameter int unsigned QUEUE_DEPTH  = 16,
  parameter int unsigned PAYLOAD_BITS = 32
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // [31:0] now_seconds, [63:32] delay_seconds, [71:64] cmd_code,
  // [79:72] subcmd_code, [111:80] payload, [115:112] slot_index, [119:116] zero
  input  logic [119:0] in_tdata,
  // [1:0] func
  input  logic [1:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // [3:0] slot, [11:4] out_cmd_code, [19:12] out_subcmd_code,
  // [51:20] out_payload, [56:52] entry_count, [63:57] zero
  output logic [63:0]  out_tdata,
  // [1:0] status
  output logic [1:0]   out_tuser
);

  localparam int unsigned DW    = stcq_pkg::DUE_W;
  localparam int unsigned CW    = stcq_pkg::CODE_W;
  localparam int unsigned PW    = stcq_pkg::PORT_PW;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned IDX_W = $clog2(QUEUE_DEPTH);

  logic [DW-1:0] in_now, in_delay;
  logic [CW-1:0] in_cmd, in_sub;
  logic [PW-1:0] in_payload;
  logic [3:0]    in_slot_index;

  assign in_now        = in_tdata[31:0];
  assign in_delay      = in_tdata[63:32];
  assign in_cmd        = in_tdata[71:64];
  assign in_sub        = in_tdata[79:72];
  assign in_payload    = in_tdata[111:80];
  assign in_slot_index = in_tdata[115:112];

  logic             out_tvalid_r, out_tvalid_nxt;
  logic in_fire;
  assign in_tready = !out_tvalid_r || out_tready;
  assign in_fire   = in_tvalid && in_tready;

  // chain with a sentinel at each end: cell i sits at index i+1
  logic [DW-1:0]           e_due   [QUEUE_DEPTH+2];
  logic [CW-1:0]           e_cmd   [QUEUE_DEPTH+2];
  logic [CW-1:0]           e_sub   [QUEUE_DEPTH+2];
  logic [PAYLOAD_BITS-1:0] e_data  [QUEUE_DEPTH+2];
  logic                    e_valid [QUEUE_DEPTH+2];
  logic [QUEUE_DEPTH:0]    cnd;
  logic [QUEUE_DEPTH-1:0]  del_sel;

  assign e_due[0]               = '0;
  assign e_cmd[0]               = '0;
  assign e_sub[0]               = '0;
  assign e_data[0]              = '0;
  assign e_valid[0]             = 1'b0;
  assign e_due[QUEUE_DEPTH+1]   = '0;
  assign e_cmd[QUEUE_DEPTH+1]   = '0;
  assign e_sub[QUEUE_DEPTH+1]   = '0;
  assign e_data[QUEUE_DEPTH+1]  = '0;
  assign e_valid[QUEUE_DEPTH+1] = 1'b0;
  assign cnd[0]                 = 1'b0;

  stcq_pkg::cell_ctrl_t    ctrl;
  logic [PAYLOAD_BITS-1:0] new_data;
  logic                    is_poll;

  logic [PW+PAYLOAD_BITS-1:0] pay_in_wide;
  assign pay_in_wide = (PW + PAYLOAD_BITS)'(in_payload);
  assign new_data    = pay_in_wide[PAYLOAD_BITS-1:0];

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    assign del_sel[i] = is_poll || (32'(i) >= 32'(in_slot_index));

    stcq_cell #(
      .PAYLOAD_BITS(PAYLOAD_BITS)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctrl       (ctrl),
      .new_data   (new_data),
      .del_sel    (del_sel[i]),
      .left_cond  (cnd[i]),
      .left_due   (e_due[i]),
      .left_cmd   (e_cmd[i]),
      .left_sub   (e_sub[i]),
      .left_data  (e_data[i]),
      .left_valid (e_valid[i]),
      .right_due  (e_due[i+2]),
      .right_cmd  (e_cmd[i+2]),
      .right_sub  (e_sub[i+2]),
      .right_data (e_data[i+2]),
      .right_valid(e_valid[i+2]),
      .cond       (cnd[i+1]),
      .due        (e_due[i+1]),
      .cmd        (e_cmd[i+1]),
      .sub        (e_sub[i+1]),
      .data       (e_data[i+1]),
      .valid      (e_valid[i+1])
    );
  end

  logic [CNT_W-1:0] count_r, count_nxt;
  logic [1:0]       status_r, status_nxt;
  logic [3:0]       slot_r, slot_nxt;
  logic [CW-1:0]    ocmd_r, ocmd_nxt;
  logic [CW-1:0]    osub_r, osub_nxt;
  logic [PW-1:0]    opay_r, opay_nxt;
  logic [4:0]       ocnt_r, ocnt_nxt;

  logic [DW:0]      due_sum;
  logic [DW-1:0]    new_due;
  logic             full;
  logic             head_due;
  logic             slot_ok;
  logic [IDX_W-1:0] pos;
  logic             any_start;

  assign due_sum  = {1'b0, in_now} + {1'b0, in_delay};
  assign new_due  = due_sum[DW] ? '1 : due_sum[DW-1:0];
  assign full     = (count_r == CNT_W'(QUEUE_DEPTH));
  assign head_due = e_valid[1] && (e_due[1] < in_now);
  assign slot_ok  = (CNT_W + 4)'(in_slot_index) < (CNT_W + 4)'(count_r);
  assign is_poll  = (in_tuser == stcq_pkg::FN_POLL);

  // the insert point is where the cell condition first goes true
  always_comb begin
    pos       = '0;
    any_start = 1'b0;
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      if (cnd[i+1] && !cnd[i]) begin
        pos       = pos | IDX_W'(i);
        any_start = 1'b1;
      end
    end
    if (!any_start) begin
      pos = IDX_W'(count_r);
    end
  end

  logic [IDX_W+3:0]            pos_wide;
  logic [CNT_W+4:0]            cnt_wide;
  logic [PAYLOAD_BITS+PW-1:0]  head_pay_wide;

  assign pos_wide      = (IDX_W + 4)'(pos);
  assign cnt_wide      = (CNT_W + 5)'(count_nxt);
  assign head_pay_wide = (PAYLOAD_BITS + PW)'(e_data[1]);

  always_comb begin
    ctrl.op        = stcq_pkg::OP_HOLD;
    ctrl.due       = new_due;
    ctrl.cmd       = in_cmd;
    ctrl.sub       = in_sub;
    count_nxt      = count_r;
    status_nxt     = stcq_pkg::ST_NONE_DUE;
    slot_nxt       = '0;
    ocmd_nxt       = '0;
    osub_nxt       = '0;
    opay_nxt       = '0;
    unique case (in_tuser)
      stcq_pkg::FN_ADD: begin
        if (full) begin
          status_nxt = stcq_pkg::ST_FULL;
        end else begin
          ctrl.op    = stcq_pkg::OP_INSERT;
          count_nxt  = count_r + 1'b1;
          status_nxt = stcq_pkg::ST_DONE;
          slot_nxt   = pos_wide[3:0];
        end
      end
      stcq_pkg::FN_REMOVE: begin
        if (slot_ok) begin
          ctrl.op    = stcq_pkg::OP_DELETE;
          count_nxt  = count_r - 1'b1;
          status_nxt = stcq_pkg::ST_DONE;
        end else begin
          status_nxt = stcq_pkg::ST_BAD_SLOT;
        end
      end
      stcq_pkg::FN_POLL: begin
        if (head_due) begin
          ctrl.op    = stcq_pkg::OP_DELETE;
          count_nxt  = count_r - 1'b1;
          status_nxt = stcq_pkg::ST_DONE;
          ocmd_nxt   = e_cmd[1];
          osub_nxt   = e_sub[1];
          opay_nxt   = head_pay_wide[PW-1:0];
        end
      end
      default: ;
    endcase
    if (!in_fire) begin
      ctrl.op   = stcq_pkg::OP_HOLD;
      count_nxt = count_r;
    end
    ocnt_nxt       = cnt_wide[4:0];
    out_tvalid_nxt = in_fire || (out_tvalid_r && !out_tready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r      <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      count_r      <= count_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      status_r <= status_nxt;
      slot_r   <= slot_nxt;
      ocmd_r   <= ocmd_nxt;
      osub_r   <= osub_nxt;
      opay_r   <= opay_nxt;
      ocnt_r   <= ocnt_nxt;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tuser  = status_r;
  assign out_tdata  = {7'd0, ocnt_r, opay_r, osub_r, ocmd_r, slot_r};

endmodule

// ----- rtl/stcq_checker.sv -----
`timescale 1ns / 1ps

module stcq_checker #(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input logic         clk,
  input logic         rst_n,
  input logic         in_tvalid,
  input logic         in_tready,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [63:0]  out_tdata,
  input logic [1:0]   out_tuser
);

  // a held result keeps its contents
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid straight after reset");

  // a full answer only comes with the queue at capacity
  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == stcq_pkg::ST_FULL) |-> out_tdata[56:52] == 5'(QUEUE_DEPTH))
    else $error("queue full reported below capacity");

  // failed items carry no slot and no popped command
  a_fail_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser != stcq_pkg::ST_DONE) |-> out_tdata[51:0] == '0)
    else $error("failed item carries data");

  // an item taken while the result is free shows up next cycle
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> out_tvalid)
    else $error("accepted item gave no result");

endmodule

bind sorted_timed_command_queue_unit stcq_checker #(
  .QUEUE_DEPTH(QUEUE_DEPTH)
) u_stcq_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_tvalid (in_tvalid),
  .in_tready (in_tready),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata),
  .out_tuser (out_tuser)
);

// ----- dv/sorted_timed_command_queue_unit_test.sv -----
`timescale 1ns / 1ps

module sorted_timed_command_queue_unit_test;

  localparam int QDEPTH = 16;
  localparam int STALL_LIMIT = 3000;
  localparam int ITEMS_PER_PHASE = 425;
  localparam logic [1:0] FN_UNUSED = 2'd3;

  typedef struct packed {
    stcq_pkg::status_t status;
    logic [3:0]  slot;
    logic [7:0]  cmd;
    logic [7:0]  sub;
    logic [31:0] payload;
    logic [4:0]  count;
  } cmd_result_t;

  // Mirrors the sorted cell row and holds the results still owed by the block.
  class due_queue_scoreboard;
    logic [31:0] due_q [QDEPTH];
    logic [7:0]  cmd_q [QDEPTH];
    logic [7:0]  sub_q [QDEPTH];
    logic [31:0] data_q [QDEPTH];
    int          depth;
    cmd_result_t awaited [$];
    int          errors;
    int          status_seen [4];

    function new();
      depth = 0;
      errors = 0;
      foreach (status_seen[i]) status_seen[i] = 0;
    endfunction

    function void shift_down(int from);
      int i;
      for (i = from; i + 1 < depth; i++) begin
        due_q[i] = due_q[i+1];
        cmd_q[i] = cmd_q[i+1];
        sub_q[i] = sub_q[i+1];
        data_q[i] = data_q[i+1];
      end
      depth--;
    endfunction

    function void note_cmd(logic [1:0] fn, logic [119:0] word);
      logic [31:0] now, delay, due;
      logic [32:0] sum;
      logic [3:0]  idx;
      int          pos, i;
      cmd_result_t r;
      now = word[31:0];
      delay = word[63:32];
      idx = word[115:112];
      r = '0;
      r.status = stcq_pkg::ST_DONE;
      case (fn)
        stcq_pkg::FN_ADD: begin
          if (depth >= QDEPTH) begin
            r.status = stcq_pkg::ST_FULL;
          end else begin
            sum = {1'b0, now} + {1'b0, delay};
            due = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
            // ties go behind existing entries
            pos = 0;
            while (pos < depth && due_q[pos] <= due) pos++;
            for (i = depth; i > pos; i--) begin
              due_q[i] = due_q[i-1];
              cmd_q[i] = cmd_q[i-1];
              sub_q[i] = sub_q[i-1];
              data_q[i] = data_q[i-1];
            end
            due_q[pos] = due;
            cmd_q[pos] = word[71:64];
            sub_q[pos] = word[79:72];
            data_q[pos] = word[111:80];
            depth++;
            r.slot = pos[3:0];
          end
        end
        stcq_pkg::FN_REMOVE: begin
          if (int'(idx) >= depth) r.status = stcq_pkg::ST_BAD_SLOT;
          else shift_down(int'(idx));
        end
        stcq_pkg::FN_POLL: begin
          // head must be strictly earlier than now
          if (depth == 0 || due_q[0] >= now) begin
            r.status = stcq_pkg::ST_NONE_DUE;
          end else begin
            r.cmd = cmd_q[0];
            r.sub = sub_q[0];
            r.payload = data_q[0];
            shift_down(0);
          end
        end
        default: r.status = stcq_pkg::ST_NONE_DUE;
      endcase
      r.count = depth[4:0];
      awaited.push_back(r);
      status_seen[r.status]++;
    endfunction

    function void compare(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $error("%s: expected %0h, actual %0h", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(logic [63:0] word, logic [1:0] st);
      cmd_result_t want;
      if (awaited.size() == 0) begin
        $error("result transfer with nothing outstanding: tdata %0h", word);
        errors++;
        return;
      end
      want = awaited.pop_front();
      compare("status", 32'(want.status), 32'(st));
      compare("slot", 32'(want.slot), 32'(word[3:0]));
      compare("out_cmd_code", 32'(want.cmd), 32'(word[11:4]));
      compare("out_subcmd_code", 32'(want.sub), 32'(word[19:12]));
      compare("out_payload", want.payload, word[51:20]);
      compare("entry_count", 32'(want.count), 32'(word[56:52]));
    endfunction
  endclass

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [119:0] in_tdata;
  logic [1:0]   in_tuser;
  logic         out_tvalid;
  logic         out_tready;
  logic [63:0]  out_tdata;
  logic [1:0]   out_tuser;

  due_queue_scoreboard sb;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          idle_cycles = 0;
  int          items_sent = 0;
  bit          filling = 1'b1;
  logic [31:0] wall = 32'd200;

  sorted_timed_command_queue_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst_n) out_tready <= 1'b0;
    else out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // outputs and ready only move on the rising edge, so the negedge view is
  // what the next edge will transfer
  always @(negedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata, out_tuser);
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("tb: no transfer for %0d cycles", STALL_LIMIT);
        $display("tb: failure");
        $finish;
      end
    end
  end

  task automatic send_cmd(input logic [1:0] fn, input logic [31:0] now,
                          input logic [31:0] delay, input logic [7:0] code,
                          input logic [7:0] sub, input logic [31:0] pay,
                          input logic [3:0] idx);
    logic [119:0] word;
    bit           hs;
    word = {4'b0, idx, pay, sub, code, delay, now};
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= fn;
    in_tdata <= word;
    do begin
      @(negedge clk);
      hs = in_tready;
      @(posedge clk);
    end while (!hs);
    sb.note_cmd(fn, word);
    items_sent++;
  endtask

  task automatic send_random();
    int unsigned pick, add_pct;
    logic [1:0]  fn;
    logic [31:0] now, delay;
    logic [3:0]  idx;
    add_pct = filling ? 65 : 25;
    pick = $urandom_range(99);
    if (pick < add_pct) fn = stcq_pkg::FN_ADD;
    else if (pick < add_pct + 18) fn = stcq_pkg::FN_REMOVE;
    else if (pick < 96) fn = stcq_pkg::FN_POLL;
    else fn = FN_UNUSED;
    wall += $urandom_range(3);
    if ($urandom_range(99) == 0) wall = $urandom;
    if ($urandom_range(9) == 0) now = $urandom;
    else now = wall;
    case ($urandom_range(9))
      0: delay = $urandom;
      1: delay = 32'hFFFF_FFFF - $urandom_range(3);
      default: delay = $urandom_range(12);
    endcase
    if (sb.depth == 0 || $urandom_range(3) == 0) idx = 4'($urandom_range(15));
    else idx = 4'($urandom_range(sb.depth - 1));
    send_cmd(fn, now, delay, 8'($urandom), 8'($urandom), $urandom, idx);
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (sb.awaited.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  initial begin
    int phase_send [4];
    int phase_recv [4];
    int ph, k;
    phase_send = '{0, 69, 0, 38};
    phase_recv = '{0, 0, 69, 38};
    sb = new();
    rst_n <= 1'b0;
    in_tvalid <= 1'b0;
    in_tuser <= stcq_pkg::FN_ADD;
    in_tdata <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty queue corners
    send_cmd(stcq_pkg::FN_POLL, 32'hFFFF_FFFF, 32'h0, 8'h0, 8'h0, 32'h0, 4'h0);
    send_cmd(FN_UNUSED, 32'h0, 32'h0, 8'h0, 8'h0, 32'h0, 4'h0);
    send_cmd(stcq_pkg::FN_REMOVE, 32'h0, 32'h0, 8'h0, 8'h0, 32'h0, 4'h0);
    // saturated due time, then two equal due times
    send_cmd(stcq_pkg::FN_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF, 8'hFF,
             32'hFFFF_FFFF, 4'hF);
    send_cmd(stcq_pkg::FN_ADD, 32'h0, 32'h0, 8'h0, 8'h0, 32'h0, 4'h0);
    send_cmd(stcq_pkg::FN_ADD, 32'h0, 32'h0, 8'hA5, 8'h5A, 32'h1234_5678, 4'h0);
    send_cmd(stcq_pkg::FN_REMOVE, 32'h0, 32'h0, 8'h0, 8'h0, 32'h0, 4'hF);
    // due equal to now is not yet due
    send_cmd(stcq_pkg::FN_POLL, 32'h0, 32'h0, 8'h0, 8'h0, 32'h0, 4'h0);
    send_cmd(stcq_pkg::FN_POLL, 32'h1, 32'h0, 8'h0, 8'h0, 32'h0, 4'h0);
    repeat (14) send_cmd(stcq_pkg::FN_ADD, 32'd100 + $urandom_range(20),
                         $urandom_range(5), 8'($urandom), 8'($urandom), $urandom,
                         4'($urandom_range(15)));
    send_cmd(stcq_pkg::FN_ADD, 32'd5, 32'd5, 8'h11, 8'h22, 32'h3333_3333, 4'h0);
    send_cmd(stcq_pkg::FN_REMOVE, 32'h0, 32'h0, 8'h0, 8'h0, 32'h0, 4'hF);
    send_cmd(stcq_pkg::FN_POLL, 32'hFFFF_FFFF, 32'h0, 8'h0, 8'h0, 32'h0, 4'h0);

    for (ph = 0; ph < 4; ph++) begin
      // sender holds off until every owed result has come back
      wait_drained();
      send_idle_pct = phase_send[ph];
      recv_stall_pct = phase_recv[ph];
      for (k = 0; k < ITEMS_PER_PHASE; k++) begin
        if (k % 60 == 0) filling = ~filling;
        send_random();
      end
    end

    wait_drained();
    repeat (4) @(posedge clk);
    $display("tb: %0d commands over 4 idle/stall mixes, queue filled and drained repeatedly",
             items_sent);
    $display("tb: status mix: %0d done, %0d full, %0d bad slot, %0d nothing due",
             sb.status_seen[stcq_pkg::ST_DONE], sb.status_seen[stcq_pkg::ST_FULL],
             sb.status_seen[stcq_pkg::ST_BAD_SLOT], sb.status_seen[stcq_pkg::ST_NONE_DUE]);
    if (sb.errors == 0 && sb.awaited.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ----- sorted_timed_command_queue_unit.f -----
rtl/stcq_pkg.sv
rtl/stcq_cell.sv
rtl/sorted_timed_command_queue_unit.sv
rtl/stcq_checker.sv
dv/sorted_timed_command_queue_unit_test.sv
